>>> hdl/mfpc_pkg.sv
// Shared types, constants and the column transpose for the page-column converter.
// No dependencies; the top level and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package mfpc_pkg;

	// Geometry of one page
	localparam int unsigned PAGE_ROWS  = 8;
	localparam int unsigned STORE_ROWS = 7;
	localparam logic [2:0]  ROW_LAST   = 3'd7;
	localparam logic [2:0]  BEAT_LAST  = 3'd7;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'b1;

	// Register reset values
	localparam logic [4:0] ROW_BYTES_RST  = 5'd12;
	localparam logic [3:0] PAGE_COUNT_RST = 4'd2;

	typedef logic [7:0]                   byte_t;
	typedef logic [STORE_ROWS-1:0][7:0]   store_rows_t;
	typedef logic [PAGE_ROWS-1:0][7:0]    col_set_t;

	// Turn seven stored row bytes plus the row 7 byte into eight column bytes:
	// bit r of column c is bit c of row r.
	function automatic col_set_t transpose(input store_rows_t rows, input byte_t px);
		col_set_t cols;
		for (int c = 0; c < PAGE_ROWS; c++) begin
			for (int r = 0; r < STORE_ROWS; r++) begin
				cols[c][r] = rows[r][c];
			end
			cols[c][PAGE_ROWS-1] = px[c];
		end
		return cols;
	endfunction

endpackage

`default_nettype wire

>>> hdl/mono_framebuffer_to_page_columns_core.sv
// A row 7 word is captured in the input stage as the row store is read, then moved on to the
// output register once that is free. Throughput: rows 0 to 6 take one word per cycle unless
// the input stage is waiting; each row 7 word gives eight column words in turn from the single
// output register, and the next row 7 word waits in the input stage until those eight have left.
// Reset: asynchronous, active low; clears counters and valids, sets the registers to 12 and 2.
// Row store contents are not cleared; a row 7 word reads whatever each row last wrote at its byte position.
`timescale 1ns / 1ps
`default_nettype none

// Top level: row store, position counters, input stage and column serialiser.
// Depends on mfpc_pkg and mfpc_ram.
module mono_framebuffer_to_page_columns_core #(
	parameter int unsigned MAX_ROW_BYTES = 16,
	parameter int unsigned MAX_PAGES     = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [mfpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mfpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         pixel_byte,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [7:0]                         column_byte,
	output logic      [6:0]                         column,
	output logic      [2:0]                         page,
	output logic                                    last_of_run,
	output logic                                    last_of_frame
);

	import mfpc_pkg::*;

	localparam int unsigned BIW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int unsigned PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam logic [5:0]  MAX_RB6 = 6'(MAX_ROW_BYTES);
	localparam logic [4:0]  MAX_PC5 = 5'(MAX_PAGES);

	// Configuration registers
	logic [4:0] row_bytes_q;
	logic [3:0] page_count_q;

	// Position counters
	logic [BIW-1:0] byte_in_row_q;
	logic [2:0]     row_in_page_q;
	logic [PW-1:0]  page_index_q;

	// Input stage (row 7 words only)
	logic           valid_s1;
	byte_t          px_s1;
	logic [BIW-1:0] bi_s1;
	logic [PW-1:0]  pg_s1;
	logic           fe_s1;
	store_rows_t    rows_s1;

	// Output stage
	logic           out_valid_q;
	col_set_t       cols_q;
	logic [2:0]     beat_q;
	logic [BIW-1:0] bi_q;
	logic [PW-1:0]  pg_q;
	logic           fe_q;

	logic        in_accept;
	logic        is_row7;
	logic        s1_move;
	logic        out_done;
	logic [5:0]  rb_eff;
	logic [4:0]  pc_eff;
	logic        row_wrap;
	logic        page_wrap;
	logic        frame_end;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= ROW_BYTES_RST;
			page_count_q <= PAGE_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_BYTES:  row_bytes_q  <= cfg_data;
				REG_PAGE_COUNT: page_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Clamp the registers into the supported range
	always_comb begin
		if (row_bytes_q == 5'd0) begin
			rb_eff = 6'd1;
		end else if ({1'b0, row_bytes_q} > MAX_RB6) begin
			rb_eff = MAX_RB6;
		end else begin
			rb_eff = {1'b0, row_bytes_q};
		end
		if (page_count_q == 4'd0) begin
			pc_eff = 5'd1;
		end else if ({1'b0, page_count_q} > MAX_PC5) begin
			pc_eff = MAX_PC5;
		end else begin
			pc_eff = {1'b0, page_count_q};
		end
	end

	// Handshake and position decode
	assign is_row7   = (row_in_page_q == ROW_LAST);
	assign out_done  = out_valid_q && out_ready && (beat_q == BEAT_LAST);
	assign s1_move   = valid_s1 && (!out_valid_q || out_done);
	assign in_ready  = !valid_s1 || s1_move;
	assign in_accept = in_valid && in_ready;
	assign row_wrap  = (6'(byte_in_row_q) + 6'd1) >= rb_eff;
	assign page_wrap = (5'(page_index_q) + 5'd1) >= pc_eff;
	assign frame_end = (5'(page_index_q) == pc_eff - 5'd1)
		&& (6'(byte_in_row_q) == rb_eff - 6'd1);

	// Advance the position counters, wrapping at row, page and frame ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q <= '0;
			row_in_page_q <= '0;
			page_index_q  <= '0;
		end else if (in_accept) begin
			if (row_wrap) begin
				byte_in_row_q <= '0;
				row_in_page_q <= row_in_page_q + 3'd1;
				if (is_row7) begin
					page_index_q <= page_wrap ? '0 : page_index_q + PW'(1);
				end
			end else begin
				byte_in_row_q <= byte_in_row_q + BIW'(1);
			end
		end
	end

	// Row store: one RAM per stored row, all read at the current byte position
	for (genvar r = 0; r < STORE_ROWS; r++) begin : g_row
		mfpc_ram #(
			.WIDTH (8),
			.DEPTH (MAX_ROW_BYTES)
		) u_row (
			.clk   (clk),
			.we    (in_accept && (row_in_page_q == 3'(r))),
			.waddr (byte_in_row_q),
			.wdata (pixel_byte),
			.re    (in_accept && is_row7),
			.raddr (byte_in_row_q),
			.rdata (rows_s1[r])
		);
	end

	// Input stage: hold a row 7 word until the serialiser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept && is_row7) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && is_row7) begin
			px_s1 <= pixel_byte;
			bi_s1 <= byte_in_row_q;
			pg_s1 <= page_index_q;
			fe_s1 <= frame_end;
		end
	end

	// Serialiser: load eight column words, step one per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			beat_q      <= '0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
			beat_q      <= '0;
		end else if (out_valid_q && out_ready) begin
			if (beat_q == BEAT_LAST) begin
				out_valid_q <= 1'b0;
			end
			beat_q <= beat_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			cols_q <= transpose(rows_s1, px_s1);
			bi_q   <= bi_s1;
			pg_q   <= pg_s1;
			fe_q   <= fe_s1;
		end
	end

	// Drive the result word
	logic [BIW+9:0] col_wide;
	logic [PW+2:0]  page_wide;

	assign col_wide      = {7'd0, bi_q, beat_q};
	assign page_wide     = {3'd0, pg_q};
	assign out_valid     = out_valid_q;
	assign column_byte   = cols_q[beat_q];
	assign column        = col_wide[6:0];
	assign page          = page_wide[2:0];
	assign last_of_run   = (beat_q == BEAT_LAST);
	assign last_of_frame = fe_q && (beat_q == BEAT_LAST);

endmodule

`default_nettype wire

>>> hdl/mfpc_ram.sv
// Generic simple dual-port RAM with registered read and read enable.
// No dependencies; one instance holds one stored row of the current page.
`timescale 1ns / 1ps
`default_nettype none

module mfpc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/mfpc_checker.sv
// Port-level checker for the page-column converter, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module mfpc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] column_byte,
	input wire logic [6:0] column,
	input wire logic       last_of_run,
	input wire logic       last_of_frame
);

	// Frame end only on the closing word of a run
	a_frame_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_frame |-> last_of_run)
		else $error("last_of_frame without last_of_run");

	// Run end marks the eighth column of a byte
	a_run_end_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_run == (column[2:0] == 3'd7)))
		else $error("last_of_run does not match column offset");

	// Words of one run follow back to back with rising column
	a_run_contig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run
		|=> out_valid && (column == $past(column) + 7'd1))
		else $error("run broken or column not consecutive");

	// A stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(column_byte) && $stable(column))
		else $error("stalled output word changed");

endmodule

bind mono_framebuffer_to_page_columns_core mfpc_checker u_mfpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.column_byte   (column_byte),
	.column        (column),
	.last_of_run   (last_of_run),
	.last_of_frame (last_of_frame)
);

`default_nettype wire

>>> tb/sv/mono_framebuffer_to_page_columns_core_test.sv
// Testbench for the page-column converter: drives row-major pixel words, predicts the
// transposed column words and checks every one, field by field, as it leaves the block.
// Depends on mfpc_pkg and mono_framebuffer_to_page_columns_core.
`timescale 1ns / 1ps

module mono_framebuffer_to_page_columns_core_test;
	import mfpc_pkg::*;

	localparam int ROW_BYTES_MAX = 16;
	localparam int PAGES_MAX     = 8;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 5000;

	typedef struct {
		byte_t      pixels;
		logic [6:0] col;
		logic [2:0] pg;
		logic       run_end;
		logic       frame_end;
	} column_word_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [7:0]            pixel_byte = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [7:0]            column_byte;
	logic [6:0]            column;
	logic [2:0]            page;
	logic                  last_of_run;
	logic                  last_of_frame;

	// Predictor state: row store, position counters and register copies
	byte_t        stored_rows [STORE_ROWS][ROW_BYTES_MAX];
	int           byte_pos       = 0;
	int           row_pos        = 0;
	int           page_pos       = 0;
	logic [4:0]   row_bytes_reg  = ROW_BYTES_RST;
	logic [3:0]   page_count_reg = PAGE_COUNT_RST;
	column_word_t expected_columns [$];

	int errors          = 0;
	int pixels_sent     = 0;
	int columns_checked = 0;
	int reg_writes      = 0;
	int cycles          = 0;
	int out_stall       = 0;
	int hold_cycles     = 0;
	bit steady          = 1'b0;

	mono_framebuffer_to_page_columns_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_byte   (pixel_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column_byte  (column_byte),
		.column       (column),
		.page         (page),
		.last_of_run  (last_of_run),
		.last_of_frame(last_of_frame)
	);

	always #5 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[mono_framebuffer_to_page_columns_core] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s of column word %0d: got %0d, want %0d",
				name, columns_checked, got, want));
	endtask

	// Store rows 0 to 6; on row 7 queue the eight column words, then advance the counters
	task automatic predict_columns(input byte_t px);
		int           rb;
		int           pc;
		int           bi;
		column_word_t w;
		rb = (row_bytes_reg == 0) ? 1 :
			(row_bytes_reg > ROW_BYTES_MAX) ? ROW_BYTES_MAX : int'(row_bytes_reg);
		pc = (page_count_reg == 0) ? 1 :
			(page_count_reg > PAGES_MAX) ? PAGES_MAX : int'(page_count_reg);
		bi = (byte_pos >= ROW_BYTES_MAX) ? ROW_BYTES_MAX - 1 : byte_pos;
		if (row_pos < STORE_ROWS) begin
			stored_rows[row_pos][bi] = px;
		end else begin
			for (int c = 0; c < 8; c++) begin
				for (int r = 0; r < STORE_ROWS; r++)
					w.pixels[r] = stored_rows[r][bi][c];
				w.pixels[7]  = px[c];
				w.col        = 7'(bi * 8 + c);
				w.pg         = 3'(page_pos);
				w.run_end    = (c == 7);
				w.frame_end  = (c == 7) && (page_pos == pc - 1) && (byte_pos == rb - 1);
				expected_columns.push_back(w);
			end
		end
		byte_pos++;
		if (byte_pos >= rb) begin
			byte_pos = 0;
			row_pos++;
			if (row_pos >= PAGE_ROWS) begin
				row_pos = 0;
				page_pos++;
				if (page_pos >= pc)
					page_pos = 0;
			end
		end
	endtask

	// Offer one pixel word after a random gap, or none in steady mode, and hold it until accepted
	task automatic send_pixel(input byte_t px);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		pixel_byte <= px;
		do @(posedge clk); while (!in_ready);
		predict_columns(px);
		pixels_sent++;
	endtask

	task automatic send_random(input int count);
		repeat (count) send_pixel(byte_t'($urandom_range(0, 255)));
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_ROW_BYTES)
			row_bytes_reg = data[4:0];
		else
			page_count_reg = data[3:0];
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, drain every expected word, then let the pipeline empty
	task automatic settle();
		int waited;
		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (expected_columns.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One page under the reset geometry
	task automatic test_reset_geometry();
		send_random(int'(ROW_BYTES_RST) * PAGE_ROWS);
		settle();
	endtask

	// One-byte rows with edge patterns; the page index left over from the previous
	// geometry lies outside the new page range and must wrap at the end of the page
	task automatic test_corner_pixels();
		byte_t corners [8];
		corners = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h0F, 8'hF0};
		write_register(REG_ROW_BYTES, 5'd1);
		write_register(REG_PAGE_COUNT, 5'd1);
		foreach (corners[i]) send_pixel(corners[i]);
		foreach (corners[i]) send_pixel(~corners[i]);
		settle();
		// zero in either register behaves as one
		write_register(REG_ROW_BYTES, 5'd0);
		write_register(REG_PAGE_COUNT, 5'd0);
		foreach (corners[i]) send_pixel(corners[7 - i]);
		settle();
	endtask

	// Eight pages of one-byte rows; hold the receiver off so the block backs up
	task automatic test_tall_frame();
		write_register(REG_ROW_BYTES, 5'd1);
		write_register(REG_PAGE_COUNT, 5'(PAGES_MAX));
		hold_cycles = 200;
		send_random(PAGE_ROWS * PAGES_MAX);
		settle();
	endtask

	// Widest row at full rate; this also fills every entry of the row store
	task automatic test_full_width();
		write_register(REG_ROW_BYTES, 5'(ROW_BYTES_MAX));
		write_register(REG_PAGE_COUNT, 5'd1);
		steady = 1'b1;
		send_random(ROW_BYTES_MAX * PAGE_ROWS);
		settle();
		steady = 1'b0;
	endtask

	// With the store fully written, change geometry in the middle of a frame
	task automatic test_mid_frame_changes();
		logic [4:0] rb;
		logic [4:0] pc;
		write_register(REG_ROW_BYTES, 5'd31);
		write_register(REG_PAGE_COUNT, 5'd15);
		send_random(16);
		repeat (6) begin
			settle();
			rb = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
			pc = 5'($urandom_range(0, 31));
			if ($urandom_range(0, 1)) begin
				write_register(REG_ROW_BYTES, rb);
				write_register(REG_PAGE_COUNT, pc);
			end else begin
				write_register(REG_PAGE_COUNT, pc);
				write_register(REG_ROW_BYTES, rb);
			end
			send_random($urandom_range(10, 24));
		end
		settle();
	endtask

	// Receiver: long hold-off first, else the stall drawn for the last word
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each accepted column word with the oldest expectation
	always @(posedge clk) begin : check_columns
		column_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_columns.size() == 0) begin
				report_mismatch($sformatf("unexpected column word: byte %0d column %0d page %0d",
					column_byte, column, page));
			end else begin
				want = expected_columns.pop_front();
				check_field("column_byte", column_byte, want.pixels);
				check_field("column", column, want.col);
				check_field("page", page, want.pg);
				check_field("last_of_run", last_of_run, want.run_end);
				check_field("last_of_frame", last_of_frame, want.frame_end);
			end
			columns_checked++;
			out_stall = steady ? 0 : $urandom_range(0, 4);
		end
	end

	initial begin
		foreach (stored_rows[r, b]) stored_rows[r][b] = 8'h00;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_geometry();
		test_corner_pixels();
		test_tall_frame();
		test_full_width();
		test_mid_frame_changes();

		if (expected_columns.size() != 0)
			report_mismatch($sformatf("%0d column words never arrived", expected_columns.size()));
		$display("run: %0d pixel words in, %0d column words out, %0d register writes",
			pixels_sent, columns_checked, reg_writes);
		$display("geometries: reset, one-byte rows, eight pages, full width, mid-frame changes");
		if (errors == 0)
			$display("[mono_framebuffer_to_page_columns_core] OK");
		else
			$display("[mono_framebuffer_to_page_columns_core] ERROR");
		$finish;
	end

endmodule

>>> files.f
hdl/mfpc_pkg.sv
hdl/mfpc_ram.sv
hdl/mono_framebuffer_to_page_columns_core.sv
hdl/mfpc_checker.sv
tb/sv/mono_framebuffer_to_page_columns_core_test.sv
